@@ rtl/lpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lpc_pkg - shared types and constants of the L1 partition chooser
// Beat payloads, register map, divider handshake and sequencer states.
// ----------------------------------------------------------------------------
package lpc_pkg;

	// divider widths: dividend covers 64 x (2^24 - 1), divisor covers local bytes
	localparam int DIV_W = 30;
	localparam int DSR_W = 24;
	localparam int CNT_W = $clog2(DIV_W);

	// data cache geometry
	localparam int CACHE_MAX_SETS = 512;
	localparam logic [12:0] MAX_SETS = 13'(CACHE_MAX_SETS);
	localparam int NUM_LEGAL = 5;
	localparam logic [10:0] LEGAL_BANKS [NUM_LEGAL] = '{
		11'd64, 11'd128, 11'd256, 11'd512, 11'd1024
	};

	// configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_BANK_BYTES  = 3'd0;
	localparam logic [2:0] REG_TOTAL_BANKS = 3'd1;
	localparam logic [2:0] REG_MIN_CACHE   = 3'd2;
	localparam logic [2:0] REG_GRANULARITY = 3'd3;
	localparam logic [2:0] REG_SLOTS       = 3'd4;
	localparam logic [2:0] REG_WARPS       = 3'd5;
	localparam logic [2:0] REG_SCALAR_REGS = 3'd6;
	localparam logic [2:0] REG_VECTOR_REGS = 3'd7;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_CAP   = 2'd1;
	localparam logic [1:0] STATUS_LOCAL_BIG = 2'd2;
	localparam logic [1:0] STATUS_NO_PART   = 2'd3;

	typedef struct packed {
		logic [12:0] bank_bytes;
		logic [11:0] total_banks;
		logic [11:0] min_data_cache_banks;
		logic [10:0] cache_bank_granularity;
		logic [6:0]  max_workgroup_slots;
		logic [6:0]  total_warps;
		logic [15:0] total_scalar_regs;
		logic [15:0] total_vector_regs;
	} cfg_t;

	typedef struct packed {
		logic [23:0] local_mem_bytes;
		logic [7:0]  warps_per_group;
		logic [7:0]  scalar_regs_per_warp;
		logic [7:0]  vector_regs_per_warp;
		logic [11:0] preset_smem_banks;
	} item_t;

	typedef struct packed {
		logic [23:0] local_mem_banks;
		logic [11:0] smem_banks;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LDS,
		S_CHECK,
		S_WARP,
		S_SREG,
		S_VREG,
		S_CAP,
		S_FIT,
		S_NEED,
		S_PICK,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_PREP,
		PH_ISSUE,
		PH_WAIT
	} div_phase_t;

endpackage

@@ rtl/lpc_div.sv @@
// ----------------------------------------------------------------------------
// lpc_div - iterative restoring divider
// One quotient bit per cycle; quotient and remainder valid with done.
// ----------------------------------------------------------------------------
module lpc_div import lpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DIV_W-1:0] quo_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             ge;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");

endmodule

@@ rtl/lpc_cfg.sv @@
// ----------------------------------------------------------------------------
// lpc_cfg - configuration register file
// APB-style write and read of the eight partition registers.
// ----------------------------------------------------------------------------
module lpc_cfg import lpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[PADDR_W-1:2];

	// write the addressed register, low bits only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bank_bytes             <= 13'd128;
			cfg_q.total_banks            <= 12'd1088;
			cfg_q.min_data_cache_banks   <= 12'd64;
			cfg_q.cache_bank_granularity <= 11'd2;
			cfg_q.max_workgroup_slots    <= 7'd8;
			cfg_q.total_warps            <= 7'd8;
			cfg_q.total_scalar_regs      <= 16'd2048;
			cfg_q.total_vector_regs      <= 16'd1024;
		end else if (wr_en) begin
			case (idx)
				REG_BANK_BYTES:  cfg_q.bank_bytes             <= pwdata[12:0];
				REG_TOTAL_BANKS: cfg_q.total_banks            <= pwdata[11:0];
				REG_MIN_CACHE:   cfg_q.min_data_cache_banks   <= pwdata[11:0];
				REG_GRANULARITY: cfg_q.cache_bank_granularity <= pwdata[10:0];
				REG_SLOTS:       cfg_q.max_workgroup_slots    <= pwdata[6:0];
				REG_WARPS:       cfg_q.total_warps            <= pwdata[6:0];
				REG_SCALAR_REGS: cfg_q.total_scalar_regs      <= pwdata[15:0];
				REG_VECTOR_REGS: cfg_q.total_vector_regs      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back the addressed register
	always_comb begin
		case (idx)
			REG_BANK_BYTES:  prdata = PDATA_W'(cfg_q.bank_bytes);
			REG_TOTAL_BANKS: prdata = PDATA_W'(cfg_q.total_banks);
			REG_MIN_CACHE:   prdata = PDATA_W'(cfg_q.min_data_cache_banks);
			REG_GRANULARITY: prdata = PDATA_W'(cfg_q.cache_bank_granularity);
			REG_SLOTS:       prdata = PDATA_W'(cfg_q.max_workgroup_slots);
			REG_WARPS:       prdata = PDATA_W'(cfg_q.total_warps);
			REG_SCALAR_REGS: prdata = PDATA_W'(cfg_q.total_scalar_regs);
			REG_VECTOR_REGS: prdata = PDATA_W'(cfg_q.total_vector_regs);
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/lpc_seq.sv @@
// ----------------------------------------------------------------------------
// lpc_seq - partition sequencer
// Steps one item through the checks, the occupancy caps and the bank split,
// running every division on the shared divider.
// ----------------------------------------------------------------------------
module lpc_seq import lpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     item_valid,
	input  item_t    item,
	output logic     busy,
	output div_req_t div_req,
	input  div_rsp_t div_rsp,
	output logic     fin_valid,
	output result_t  fin,
	input  logic     fin_take
);

	seq_state_t state_q, state_d;
	div_phase_t phase_q, phase_d;

	item_t            item_q;
	logic [23:0]      lds_banks_q;
	logic [11:0]      smem_q;
	logic [1:0]       status_q;
	logic [6:0]       res_q;
	logic [11:0]      slack_q;
	logic [11:0]      need_q;
	logic [DIV_W-1:0] prod_q;

	logic [23:0]      mul_a;
	logic [12:0]      mul_b;
	logic [36:0]      prod;
	logic [DIV_W-1:0] dividend;
	logic [DSR_W-1:0] divisor;
	logic [DIV_W-1:0] ceil_q;
	logic             q_lt_res;
	logic             div_state;

	logic                 gran_pow2;
	logic [3:0]           gran_log2;
	logic [NUM_LEGAL-1:0] legal_ok;
	logic [10:0]          cmin;
	logic [10:0]          best;
	logic [11:0]          avail;
	logic                 cap_fail;

	// legal data cache sizes under granularity, set count and minimum
	always_comb begin
		gran_pow2 = (cfg.cache_bank_granularity != '0) &&
			((cfg.cache_bank_granularity & (cfg.cache_bank_granularity - 1'b1)) == '0);
		gran_log2 = '0;
		for (int i = 0; i < 11; i++) begin
			if (cfg.cache_bank_granularity[i]) gran_log2 = 4'(i);
		end
		for (int k = 0; k < NUM_LEGAL; k++) begin
			legal_ok[k] = gran_pow2 &&
				(LEGAL_BANKS[k] >= cfg.cache_bank_granularity) &&
				({2'b0, LEGAL_BANKS[k] >> gran_log2} <= MAX_SETS) &&
				({1'b0, LEGAL_BANKS[k]} >= cfg.min_data_cache_banks);
		end
	end

	// smallest legal size, and largest one that fits what is left
	assign avail = cfg.total_banks - need_q;
	always_comb begin
		cmin = '0;
		for (int k = NUM_LEGAL - 1; k >= 0; k--) begin
			if (legal_ok[k]) cmin = LEGAL_BANKS[k];
		end
		best = '0;
		for (int k = 0; k < NUM_LEGAL; k++) begin
			if (legal_ok[k] && ({1'b0, LEGAL_BANKS[k]} <= avail)) best = LEGAL_BANKS[k];
		end
	end

	assign cap_fail = (res_q == '0) || (legal_ok == '0) || ({1'b0, cmin} > cfg.total_banks);

	// shared multiplier operands
	always_comb begin
		case (state_q)
			S_LDS:   begin mul_a = item_q.local_mem_bytes;             mul_b = 13'd1; end
			S_WARP:  begin mul_a = 24'(cfg.total_warps);               mul_b = 13'd1; end
			S_SREG:  begin
				mul_a = 24'(item_q.warps_per_group);
				mul_b = 13'(item_q.scalar_regs_per_warp);
			end
			S_VREG:  begin
				mul_a = 24'(item_q.warps_per_group);
				mul_b = 13'(item_q.vector_regs_per_warp);
			end
			S_FIT:   begin mul_a = 24'(slack_q);                       mul_b = cfg.bank_bytes; end
			S_NEED:  begin mul_a = item_q.local_mem_bytes;             mul_b = 13'(res_q); end
			default: begin mul_a = '0;                                 mul_b = '0; end
		endcase
	end
	assign prod = mul_a * mul_b;

	// divider operands
	always_comb begin
		case (state_q)
			S_LDS:   begin dividend = prod_q; divisor = DSR_W'(cfg.bank_bytes); end
			S_WARP:  begin dividend = prod_q; divisor = DSR_W'(item_q.warps_per_group); end
			S_SREG:  begin
				dividend = DIV_W'(cfg.total_scalar_regs);
				divisor  = prod_q[DSR_W-1:0];
			end
			S_VREG:  begin
				dividend = DIV_W'(cfg.total_vector_regs);
				divisor  = prod_q[DSR_W-1:0];
			end
			S_FIT:   begin dividend = prod_q; divisor = item_q.local_mem_bytes; end
			S_NEED:  begin dividend = prod_q; divisor = DSR_W'(cfg.bank_bytes); end
			default: begin dividend = '0;     divisor = '0; end
		endcase
	end

	assign ceil_q   = div_rsp.quotient + DIV_W'(div_rsp.remainder != '0);
	assign q_lt_res = div_rsp.quotient < DIV_W'(res_q);
	assign div_state = (state_q == S_LDS) || (state_q == S_WARP) || (state_q == S_SREG) ||
		(state_q == S_VREG) || (state_q == S_FIT) || (state_q == S_NEED);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_PREP;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state and divider start
	always_comb begin
		state_d          = state_q;
		phase_d          = phase_q;
		div_req.start    = 1'b0;
		div_req.dividend = dividend;
		div_req.divisor  = divisor;
		case (state_q)
			S_IDLE: begin
				phase_d = PH_PREP;
				if (item_valid) state_d = S_LDS;
			end
			S_LDS, S_WARP, S_SREG, S_VREG, S_FIT, S_NEED: begin
				case (phase_q)
					PH_PREP: phase_d = PH_ISSUE;
					PH_ISSUE: begin
						if (divisor == '0) begin
							phase_d = PH_PREP;
							case (state_q)
								S_LDS:   state_d = S_DONE;
								S_WARP:  state_d = S_SREG;
								S_SREG:  state_d = S_VREG;
								S_VREG:  state_d = S_CAP;
								S_FIT:   state_d = S_NEED;
								default: state_d = S_PICK;
							endcase
						end else begin
							div_req.start = 1'b1;
							phase_d       = PH_WAIT;
						end
					end
					PH_WAIT: begin
						if (div_rsp.done) begin
							phase_d = PH_PREP;
							case (state_q)
								S_LDS:   state_d = S_CHECK;
								S_WARP:  state_d = S_SREG;
								S_SREG:  state_d = S_VREG;
								S_VREG:  state_d = S_CAP;
								S_FIT:   state_d = (div_rsp.quotient == '0) ? S_DONE : S_NEED;
								default: state_d = S_PICK;
							endcase
						end
					end
					default: phase_d = PH_PREP;
				endcase
			end
			S_CHECK: begin
				if ((cfg.total_banks <= cfg.min_data_cache_banks) ||
					(lds_banks_q > 24'(cfg.total_banks - cfg.min_data_cache_banks)) ||
					(item_q.preset_smem_banks != '0)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WARP;
				end
			end
			S_CAP:   state_d = cap_fail ? S_DONE : S_FIT;
			S_PICK:  state_d = S_DONE;
			S_DONE:  if (fin_take) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					item_q      <= item;
					lds_banks_q <= '0;
					smem_q      <= '0;
					status_q    <= STATUS_OK;
				end
			end
			S_CHECK: begin
				if (cfg.total_banks <= cfg.min_data_cache_banks) begin
					status_q <= STATUS_BAD_CAP;
				end else if (lds_banks_q > 24'(cfg.total_banks - cfg.min_data_cache_banks)) begin
					status_q <= STATUS_LOCAL_BIG;
				end else if (item_q.preset_smem_banks != '0) begin
					smem_q <= item_q.preset_smem_banks;
				end else begin
					res_q <= cfg.max_workgroup_slots;
				end
			end
			S_CAP: begin
				if (cap_fail) status_q <= STATUS_NO_PART;
				else slack_q <= cfg.total_banks - {1'b0, cmin};
			end
			S_PICK: smem_q <= cfg.total_banks - {1'b0, best};
			default: ;
		endcase

		// latch the product ahead of each division
		if (div_state && (phase_q == PH_PREP)) prod_q <= prod[DIV_W-1:0];

		// zero bank size ends the item at once
		if ((state_q == S_LDS) && (phase_q == PH_ISSUE) && (divisor == '0))
			status_q <= STATUS_BAD_CAP;

		// take division results
		if (div_state && (phase_q == PH_WAIT) && div_rsp.done) begin
			case (state_q)
				S_LDS:  lds_banks_q <= ceil_q[23:0];
				S_WARP, S_SREG, S_VREG: if (q_lt_res) res_q <= div_rsp.quotient[6:0];
				S_FIT: begin
					if (q_lt_res) res_q <= div_rsp.quotient[6:0];
					if (div_rsp.quotient == '0) status_q <= STATUS_NO_PART;
				end
				S_NEED: need_q <= ceil_q[11:0];
				default: ;
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign fin_valid       = (state_q == S_DONE);
	assign fin.local_mem_banks = lds_banks_q;
	assign fin.smem_banks      = smem_q;
	assign fin.status          = status_q;

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_need_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK) |-> (need_q <= slack_q) && (res_q != '0))
		else $error("shared memory need exceeds the bank slack");

endmodule

@@ rtl/l1_smem_partition_chooser.sv @@
// ----------------------------------------------------------------------------
// l1_smem_partition_chooser - unified L1 shared memory / data cache split
// Rounds a kernel's local memory to banks and picks the shared memory bank
// count for one launch.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (item_valid / item_stall / item) carry one kernel's local
//   memory bytes, warps per group, register use and an optional preset
//   split. Each input beat yields exactly one result beat (result_valid /
//   result_stall / result) with the rounded bank count, the shared memory
//   bank count and a status code.
//   Registers are to be written via the APB-style port only while the block
//   idles (not enforced). pready stays high; reads return the register value.
// Flow:
//   Up to six divisions share one restoring divider, each passing through
//   setup, start, the quotient bits and done; a zero divisor skips the
//   division at its start step. A preset or a capacity error ends the item
//   after its first division, and a zero bank size ends it before that runs.
//   item_stall stays high until the sequencer idles again, so no new item is
//   accepted while one is still in progress.
// Reset and stall:
//   Reset restores the register defaults and empties the block. A finished
//   result sits in the output register; the next item is accepted while it
//   waits, and the sequencer holds its own result until that register frees.
// ----------------------------------------------------------------------------
module l1_smem_partition_chooser import lpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     seq_busy;
	logic     fin_valid;
	result_t  fin;
	logic     fin_take;
	logic     result_valid_q;
	result_t  result_q;

	lpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lpc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.busy       (seq_busy),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.fin_valid  (fin_valid),
		.fin        (fin),
		.fin_take   (fin_take)
	);

	assign item_stall = seq_busy;

	// output register: load when empty or draining, hold while stalled
	assign fin_take = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fin_valid && fin_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_take) result_q <= fin;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input not held off after an accepted beat");

	a_fin_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid && fin_take) |=> result_valid && !fin_valid)
		else $error("finished result not moved to the output register");

endmodule
